// File: rtl/core/glef_pkg.sv
// glef_pkg: types, constants and helpers shared by the gray Laplacian edge filter.
// No dependencies; every module of the filter refers to it by scoped names.
package glef_pkg;

  localparam int MAX_WIDTH_DEFAULT = 4096;
  localparam int HEIGHT_LIMIT      = 4096;
  localparam int DIM_MIN           = 3;
  localparam int WIDTH_RESET       = 640;
  localparam int HEIGHT_RESET      = 480;

  localparam int DIM_W      = 13;  // config register width
  localparam int ROW_W      = 13;  // input row counter, reaches HEIGHT_LIMIT
  localparam int OROW_W     = 12;  // output row counter
  localparam int CFG_IDX_W  = 1;
  localparam int QUEUE_DEPTH = 4;

  // floor(x/3) for x <= 765 as (x * 683) >> 11
  localparam int GRAY_SUM_W  = 10;
  localparam int GRAY_RECIP  = 683;
  localparam int GRAY_SHIFT  = 11;
  localparam int GRAY_PROD_W = 20;

  localparam logic KIND_PIXEL = 1'b0;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] edge_value;
    logic [7:0] gray_value;
    logic       frame_last;
  } result_item_t;

  // what the back end has to do with one word
  typedef struct packed {
    logic write;   // pixel goes into the line stores and the window
    logic emit;    // word yields a frame result
    logic border;  // that result sits on the image border
    logic last;    // that result is the frame's final pixel
  } work_flags_t;

  function automatic int dim_clamp(input logic [DIM_W-1:0] v, input int hi);
    int x;
    x = int'(v);
    if (x < DIM_MIN) x = DIM_MIN;
    if (x > hi) x = hi;
    return x;
  endfunction

endpackage

// File: rtl/core/glef_queue.sv
// glef_queue: small FIFO decoupling the filter front end from the back end.
// Depth from glef_pkg; payload width set by the instantiating module.
module glef_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  output logic             valid,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata
);

  localparam int Depth = glef_pkg::QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  logic [WIDTH-1:0] slots [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CntW'(Depth));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// File: rtl/core/glef_front.sv
// glef_front: takes input words, computes gray, tracks frame position and
// decides per word what the back end does. Uses glef_pkg.
module glef_front #(
  parameter int MAX_WIDTH = glef_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  glef_pkg::pixel_item_t            item,
  input  logic                             cfg_write,
  input  logic [glef_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [glef_pkg::DIM_W-1:0]       cfg_data,
  output glef_pkg::work_flags_t            flags,
  output logic [7:0]                       gray,
  output logic [$clog2(MAX_WIDTH)-1:0]     col
);

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int RowW  = glef_pkg::ROW_W;
  localparam int ORowW = glef_pkg::OROW_W;

  logic [ColW-1:0]  width_m1;
  logic [ORowW-1:0] height_m1;
  logic [ColW-1:0]  in_col;
  logic [RowW-1:0]  in_row;
  logic [ColW-1:0]  out_col;
  logic [ORowW-1:0] out_row;

  logic [glef_pkg::GRAY_SUM_W-1:0]  rgb_sum;
  logic [glef_pkg::GRAY_PROD_W-1:0] gray_prod;
  logic                             is_pixel;
  logic                             frame_open;
  logic                             take;
  logic                             primed;
  logic                             emit;
  logic                             border;
  logic                             last;

  always_comb begin
    rgb_sum   = glef_pkg::GRAY_SUM_W'(item.red) + glef_pkg::GRAY_SUM_W'(item.green)
              + glef_pkg::GRAY_SUM_W'(item.blue);
    gray_prod = glef_pkg::GRAY_PROD_W'(rgb_sum)
              * glef_pkg::GRAY_PROD_W'(glef_pkg::GRAY_RECIP);
    is_pixel   = (item.kind == glef_pkg::KIND_PIXEL);
    frame_open = (in_row <= {1'b0, height_m1});
    take       = is_pixel && frame_open;
    // first result is due once pixel W+1 of the frame arrives
    primed     = (in_row >= RowW'(2)) || ((in_row == RowW'(1)) && (in_col != '0));
    emit       = take ? primed : !frame_open;
    border     = (out_row == '0) || (out_row == height_m1)
              || (out_col == '0) || (out_col == width_m1);
    last       = (out_row == height_m1) && (out_col == width_m1);
    gray       = is_pixel ? gray_prod[glef_pkg::GRAY_SHIFT +: 8] : 8'd0;
    flags      = '{write: take, emit: emit, border: border, last: last};
    col        = in_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_m1  <= ColW'(glef_pkg::dim_clamp(glef_pkg::DIM_W'(glef_pkg::WIDTH_RESET),
                                             MAX_WIDTH) - 1);
      height_m1 <= ORowW'(glef_pkg::dim_clamp(glef_pkg::DIM_W'(glef_pkg::HEIGHT_RESET),
                                              glef_pkg::HEIGHT_LIMIT) - 1);
      in_col    <= '0;
      in_row    <= '0;
      out_col   <= '0;
      out_row   <= '0;
    end else if (cfg_write) begin
      if (cfg_index == glef_pkg::REG_IMAGE_WIDTH) begin
        width_m1 <= ColW'(glef_pkg::dim_clamp(cfg_data, MAX_WIDTH) - 1);
      end else if (cfg_index == glef_pkg::REG_IMAGE_HEIGHT) begin
        height_m1 <= ORowW'(glef_pkg::dim_clamp(cfg_data, glef_pkg::HEIGHT_LIMIT) - 1);
      end
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (accept) begin
      if (emit && last) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (take) begin
          if (in_col == width_m1) begin
            in_col <= '0;
            in_row <= in_row + 1'b1;
          end else begin
            in_col <= in_col + 1'b1;
          end
        end
        if (emit) begin
          if (out_col == width_m1) begin
            out_col <= '0;
            out_row <= out_row + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
      end
    end
  end

endmodule

// File: rtl/core/glef_back.sv
// glef_back: line stores, 3x3 window, Laplacian and the result register.
// Pulls words from glef_queue; types from glef_pkg.
module glef_back #(
  parameter int MAX_WIDTH = glef_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  glef_pkg::work_flags_t         q_flags,
  input  logic [7:0]                    q_gray,
  input  logic [$clog2(MAX_WIDTH)-1:0]  q_col,
  output logic                          result_valid,
  input  logic                          result_ready,
  output glef_pkg::result_item_t        result
);

  localparam int ColW = $clog2(MAX_WIDTH);

  logic [7:0] upper_mem  [MAX_WIDTH];
  logic [7:0] middle_mem [MAX_WIDTH];
  logic [7:0] rd_top;
  logic [7:0] rd_mid;

  // stage A: line store read in flight
  logic                  a_valid;
  glef_pkg::work_flags_t a_flags;
  logic [7:0]            a_gray;
  logic [ColW-1:0]       a_col;
  logic                  a_adv;

  // stage W: window holds the neighborhood of this word's result
  logic                  w_valid;
  glef_pkg::work_flags_t w_flags;
  logic [7:0]            w_gray;
  logic                  w_adv;

  logic [7:0] win [3][3];

  logic [10:0]       nbr_sum;
  logic signed [11:0] acc;
  logic [7:0]        lap;

  assign w_adv = w_valid && (!result_valid || result_ready);
  assign a_adv = a_valid && (!w_valid || w_adv);
  assign q_pop = q_valid && (!a_valid || a_adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      w_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (a_adv) begin
        w_valid <= 1'b1;
      end else if (w_adv) begin
        w_valid <= 1'b0;
      end
      if (w_adv) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_flags <= q_flags;
      a_gray  <= q_gray;
      a_col   <= q_col;
      if (q_flags.write) begin
        rd_top <= upper_mem[q_col];
        rd_mid <= middle_mem[q_col];
      end
    end
    if (a_adv) begin
      w_flags <= a_flags;
      w_gray  <= a_gray;
      if (a_flags.write) begin
        upper_mem[a_col]  <= rd_mid;
        middle_mem[a_col] <= a_gray;
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[0][2] <= rd_top;
        win[1][2] <= rd_mid;
        win[2][2] <= a_gray;
      end
    end
    if (w_adv) begin
      result.out_valid  <= w_flags.emit;
      result.edge_value <= (w_flags.emit && !w_flags.border) ? lap : 8'd0;
      result.gray_value <= w_gray;
      result.frame_last <= w_flags.emit && w_flags.last;
    end
  end

  always_comb begin
    nbr_sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (r != 1 || c != 1) begin
          nbr_sum = nbr_sum + 11'(win[r][c]);
        end
      end
    end
    acc = $signed({1'b0, win[1][1], 3'b000}) - $signed({1'b0, nbr_sum});
    if (acc < 0) begin
      lap = 8'd0;
    end else if (acc > 12'sd255) begin
      lap = 8'd255;
    end else begin
      lap = acc[7:0];
    end
  end

endmodule

// File: rtl/core/gray_laplacian_edge_filter.sv
// gray_laplacian_edge_filter: top level of the streaming 3x3 Laplacian edge filter.
// Instantiates glef_front, glef_queue and glef_back; types from glef_pkg.
//
// Usage:
//   pixel channel (pixel_valid/pixel_ready/pixel): one word per pixel in raster
//   order, or a flush word (kind = 1) that drains the frame's tail results.
//   result channel (result_valid/result_ready/result): exactly one word per
//   input word, in order. out_valid marks a frame result; the result for pixel
//   q rides on the word of input q+W+1, the last W+1 on flush words.
//   cfg channel: index 0 image width, 1 image height; a write restarts the
//   frame. cfg_ready is always high; write only while the block is idle.
// Timing: a word passes through the queue, stage A, stage W and the result register;
//   one word per cycle sustained while result_ready stays high, as each line store
//   takes one read and one write per cycle, at different columns.
// Reset: 640x480 frame, counters cleared; line stores are not cleared.
// Stall: a stalled result holds; the 4-entry queue keeps taking input until
//   it fills, then pixel_ready drops.
module gray_laplacian_edge_filter #(
  parameter int MAX_WIDTH = glef_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pixel_valid,
  output logic                            pixel_ready,
  input  glef_pkg::pixel_item_t           pixel,
  output logic                            result_valid,
  input  logic                            result_ready,
  output glef_pkg::result_item_t          result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [glef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [glef_pkg::DIM_W-1:0]      cfg_data
);

  localparam int ColW   = $clog2(MAX_WIDTH);
  localparam int FlagsW = $bits(glef_pkg::work_flags_t);
  localparam int QW     = ColW + 8 + FlagsW;

  logic                  accept;
  logic                  cfg_write;
  glef_pkg::work_flags_t f_flags;
  logic [7:0]            f_gray;
  logic [ColW-1:0]       f_col;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  logic [QW-1:0]         q_rdata;
  glef_pkg::work_flags_t q_flags;
  logic [7:0]            q_gray;
  logic [ColW-1:0]       q_col;

  assign pixel_ready = !q_full;
  assign accept      = pixel_valid && pixel_ready;
  assign cfg_ready   = 1'b1;
  assign cfg_write   = cfg_valid && cfg_ready;
  assign {q_col, q_gray, q_flags} = q_rdata;

  glef_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (pixel),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .flags     (f_flags),
    .gray      (f_gray),
    .col       (f_col)
  );

  glef_queue #(.WIDTH(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata ({f_col, f_gray, f_flags}),
    .full  (q_full),
    .valid (q_valid),
    .pop   (q_pop),
    .rdata (q_rdata)
  );

  glef_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_flags      (q_flags),
    .q_gray       (q_gray),
    .q_col        (q_col),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // a word without a frame result carries no edge and no frame end
  a_idle_result_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.out_valid |-> result.edge_value == 8'd0 && !result.frame_last)
    else $error("idle result word carries edge or frame end");

  // the frame's last pixel is a corner, so its edge is zero
  a_last_is_border: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_last |-> result.out_valid && result.edge_value == 8'd0)
    else $error("frame end result has nonzero edge");

  // the queue only becomes or stays full while the back end takes nothing
  a_queue_fill: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !$past(q_pop))
    else $error("queue full after a pop");

endmodule
